>>> rtl/core/mds8_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mds8_pkg: shared types and constants for the 8x8 mono coverage downsampler
// Sizes of the column store and the position counters, register indexes,
// and the masked popcount used on each input item.
// ----------------------------------------------------------------------------
package mds8_pkg;

	localparam int MAX_COLUMNS = 64;
	localparam int MAX_ROWS    = 512;

	localparam int COL_W  = $clog2(MAX_COLUMNS);   // byte column index
	localparam int ROW_W  = $clog2(MAX_ROWS);      // source row index
	localparam int CFG_W  = 10;                    // register width
	localparam int BYTES_W = COL_W + 1;            // bytes per row, up to MAX_COLUMNS
	localparam int COV_W  = 7;                     // 0..64
	localparam int POP_W  = 4;                     // 0..8
	localparam int IDX_W  = 2;

	localparam logic [CFG_W-1:0] MAX_WIDTH_PX = CFG_W'(MAX_COLUMNS * 8);
	localparam logic [CFG_W-1:0] MAX_HEIGHT   = CFG_W'(MAX_ROWS);
	localparam logic [CFG_W-1:0] WIDTH_RST    = CFG_W'(8);
	localparam logic [CFG_W-1:0] HEIGHT_RST   = CFG_W'(8);

	typedef enum logic [IDX_W-1:0] {
		CFG_GLYPH_WIDTH  = 2'd0,
		CFG_GLYPH_HEIGHT = 2'd1
	} cfg_idx_t;

	// write side of the column store; keep low clears the entry
	typedef struct packed {
		logic             en;
		logic             keep;
		logic [COL_W-1:0] addr;
		logic [COV_W-1:0] data;
	} col_wr_t;

	function automatic logic [POP_W-1:0] count_bits(input logic [7:0] v);
		logic [7:0] n;
		n = (v & 8'h55) + ((v & 8'haa) >> 1);
		n = (n & 8'h33) + ((n & 8'hcc) >> 2);
		n = (n & 8'h0f) + ((n & 8'hf0) >> 4);
		return n[POP_W-1:0];
	endfunction

	// keeps the leftmost n pixels, n in 1..7
	function automatic logic [7:0] tail_mask(input logic [2:0] n);
		logic [3:0] sh;
		sh = 4'd8 - {1'b0, n};
		return 8'hff << sh;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/mds8_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mds8 channel interfaces
// Valid/ready channels for pixel bytes in and coverage cells out.
// ----------------------------------------------------------------------------
interface mds8_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;

	modport source (output valid, output pixel_byte, input ready);
	modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface mds8_cov_if;
	logic                     valid;
	logic                     ready;
	logic [mds8_pkg::COV_W-1:0] coverage;
	logic                     end_of_row;
	logic                     end_of_glyph;

	modport source (output valid, output coverage, output end_of_row,
		output end_of_glyph, input ready);
	modport sink   (input valid, input coverage, input end_of_row,
		input end_of_glyph, output ready);
endinterface
`default_nettype wire

>>> rtl/core/mono_downsample_8x8_coverage_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mono_downsample_8x8_coverage_unit: 1bpp glyph to 8x8 box coverage
// Accumulates masked byte popcounts per byte column and emits one cell per
// byte on the last row of each 8-row band and on the glyph's last row.
// ----------------------------------------------------------------------------
// Takes one pixel byte per clock with no gaps of its own. An item is held in
// one stage while its column's running sum is read from a 64 x 7 RAM (read
// data registered, same-column back-to-back reads forwarded); when the stage
// advances it writes the sum back and, on a flushing row, loads the output
// register, from which the result is visible. Input stalls only when a
// flushing item finds the output register full and not being drained.
// Accumulators are marked empty by per-column flags, so there is no clearing
// pass after reset. Writing either register restarts the glyph.
module mono_downsample_8x8_coverage_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [mds8_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [mds8_pkg::CFG_W-1:0]    cfg_wdata,
	mds8_pix_if.sink                           pix,
	mds8_cov_if.source                         cov
);

	logic [mds8_pkg::CFG_W-1:0] width_q;
	logic [mds8_pkg::CFG_W-1:0] height_q;
	logic [mds8_pkg::COL_W-1:0] col_q;
	logic [mds8_pkg::ROW_W-1:0] row_q;

	logic [mds8_pkg::CFG_W-1:0]   eff_w;
	logic [mds8_pkg::CFG_W-1:0]   eff_h;
	logic [mds8_pkg::CFG_W-1:0]   w_round;
	logic [mds8_pkg::BYTES_W-1:0] bytes;
	logic                         last_col;
	logic                         last_row;
	logic [7:0]                   masked;
	logic                         accept;
	logic                         restart;

	logic                         valid_s1;
	logic [mds8_pkg::POP_W-1:0]   pop_s1;
	logic [mds8_pkg::COL_W-1:0]   col_s1;
	logic                         flush_s1;
	logic                         eor_s1;
	logic                         eog_s1;
	logic                         adv_s1;
	logic                         out_free;

	logic [mds8_pkg::COV_W-1:0]   base;
	logic [mds8_pkg::COV_W-1:0]   sum;
	mds8_pkg::col_wr_t            wr;

	logic                         out_valid_q;
	logic [mds8_pkg::COV_W-1:0]   cov_q;
	logic                         eor_q;
	logic                         eog_q;

	assign restart = cfg_we && ((cfg_index == mds8_pkg::CFG_GLYPH_WIDTH)
		|| (cfg_index == mds8_pkg::CFG_GLYPH_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mds8_pkg::WIDTH_RST;
			height_q <= mds8_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mds8_pkg::CFG_GLYPH_WIDTH:  width_q  <= cfg_wdata;
				mds8_pkg::CFG_GLYPH_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// effective geometry, zero and oversize clamped
	always_comb begin
		eff_w = width_q;
		if (width_q == '0) begin
			eff_w = mds8_pkg::CFG_W'(1);
		end else if (width_q > mds8_pkg::MAX_WIDTH_PX) begin
			eff_w = mds8_pkg::MAX_WIDTH_PX;
		end
		eff_h = height_q;
		if (height_q == '0) begin
			eff_h = mds8_pkg::CFG_W'(1);
		end else if (height_q > mds8_pkg::MAX_HEIGHT) begin
			eff_h = mds8_pkg::MAX_HEIGHT;
		end
		// eff_w is at most 512, so the rounded width stays within CFG_W bits
		w_round  = eff_w + mds8_pkg::CFG_W'(7);
		bytes    = w_round[mds8_pkg::CFG_W-1:3];
		last_col = ({1'b0, col_q} == (bytes - mds8_pkg::BYTES_W'(1)));
		last_row = ({1'b0, row_q} == (eff_h - mds8_pkg::CFG_W'(1)));
		masked   = pix.pixel_byte;
		if (last_col && (eff_w[2:0] != 3'd0)) begin
			masked = pix.pixel_byte & mds8_pkg::tail_mask(eff_w[2:0]);
		end
	end

	assign out_free  = !out_valid_q || cov.ready;
	assign adv_s1    = !flush_s1 || out_free;
	assign pix.ready = !valid_s1 || adv_s1;
	assign accept    = pix.valid && pix.ready;

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + mds8_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + mds8_pkg::COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_s1   <= mds8_pkg::count_bits(masked);
			col_s1   <= col_q;
			flush_s1 <= (row_q[2:0] == 3'd7) || last_row;
			eor_s1   <= last_col;
			eog_s1   <= last_col && last_row;
		end
	end

	assign sum = base + mds8_pkg::COV_W'(pop_s1);

	always_comb begin
		wr.en   = valid_s1 && adv_s1;
		wr.keep = !flush_s1;
		wr.addr = col_s1;
		wr.data = sum;
	end

	mds8_colstore u_colstore (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (restart),
		.rd_en   (accept),
		.rd_addr (col_q),
		.wr      (wr),
		.rd_data (base)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr.en && flush_s1) begin
			out_valid_q <= 1'b1;
		end else if (cov.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && flush_s1) begin
			cov_q <= sum;
			eor_q <= eor_s1;
			eog_q <= eog_s1;
		end
	end

	assign cov.valid        = out_valid_q;
	assign cov.coverage     = cov_q;
	assign cov.end_of_row   = eor_q;
	assign cov.end_of_glyph = eog_q;

	// a cell covers at most 64 pixels
	a_cov_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (cov_q <= mds8_pkg::COV_W'(64)))
		else $error("coverage above 64");

	a_eog_eor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && eog_q |-> eor_q)
		else $error("end of glyph without end of row");

	// a flushing item that cannot leave must stay put
	a_flush_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && flush_s1 && !out_free |=> valid_s1 && $stable(col_s1))
		else $error("flushing item lost while output blocked");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < bytes)
		else $error("byte column beyond row length");

endmodule
`default_nettype wire

>>> rtl/core/mds8_colstore.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mds8_colstore: per-column coverage accumulators
// Single-port-write, registered-read RAM with a valid flag per entry; an
// invalid entry reads as zero. A read on the same edge as a write to the
// same column picks up the written value.
// ----------------------------------------------------------------------------
module mds8_colstore (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         clear,
	input  wire logic                         rd_en,
	input  wire logic [mds8_pkg::COL_W-1:0]   rd_addr,
	input  wire mds8_pkg::col_wr_t            wr,
	output logic      [mds8_pkg::COV_W-1:0]   rd_data
);

	logic [mds8_pkg::COV_W-1:0] mem [mds8_pkg::MAX_COLUMNS];
	logic [mds8_pkg::MAX_COLUMNS-1:0] vld_q;
	logic [mds8_pkg::COV_W-1:0] rdata_q;
	logic                       rvld_q;
	logic                       byp_q;
	logic [mds8_pkg::COV_W-1:0] bypd_q;

	always_ff @(posedge clk) begin
		if (wr.en && wr.keep) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
			rvld_q  <= vld_q[rd_addr];
			byp_q   <= wr.en && (wr.addr == rd_addr);
			bypd_q  <= wr.keep ? wr.data : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clear) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= wr.keep;
		end
	end

	always_comb begin
		if (byp_q) begin
			rd_data = bypd_q;
		end else if (rvld_q) begin
			rd_data = rdata_q;
		end else begin
			rd_data = '0;
		end
	end

endmodule
`default_nettype wire
